// ===== hw/rtl/onp_pkg.sv =====
// ----------------------------------------------------------------------------
// onp_pkg: shared types and constants of the octal netstring parser
// beat layouts, phase codes, result kinds and status codes
// ----------------------------------------------------------------------------
package onp_pkg;

  localparam int ONP_POS_BITS = 16;
  localparam int ONP_OFF_W    = 16;
  localparam int ONP_LEN_W    = 16;

  // character constants
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // result kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // error status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_FMT = 2'd1;
  localparam logic [1:0] ST_BIG = 2'd2;
  localparam logic [1:0] ST_INC = 2'd3;

  typedef enum logic [4:0] {
    PH_WS    = 5'b00001,
    PH_LEN   = 5'b00010,
    PH_DATA  = 5'b00100,
    PH_COMMA = 5'b01000,
    PH_DROP  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           payload_byte;
    logic [1:0]           status;
    logic [ONP_OFF_W-1:0] frame_offset;
    logic [ONP_LEN_W-1:0] frame_length;
    logic [ONP_OFF_W-1:0] next_offset;
  } out_beat_t;

  // frame state of fixed width
  typedef struct packed {
    phase_t               phase;
    logic [ONP_LEN_W-1:0] length_acc;
    logic [ONP_LEN_W-1:0] remaining;
    logic                 digit_seen;
  } frame_st_t;

endpackage

// ===== hw/rtl/octal_netstring_parser.sv =====
// ----------------------------------------------------------------------------
// octal_netstring_parser: deframer for netstrings with an octal length prefix
// one byte in, one result beat out, state held between bytes
// ----------------------------------------------------------------------------
// Takes one buffer byte per input beat and returns exactly one result beat
// per byte: nothing (whitespace, prefix digits, colon), a payload byte, a
// frame-complete report with offset, length and next offset, or an error
// (format, too large, incomplete). The block runs at one byte per clock:
// each byte passes through a single step of compare and shift logic from
// the frame registers into the result register, so a new byte is taken
// every cycle while the result register is free or being emptied. The
// result beat is registered in the cycle after its byte is taken. After
// an error bytes are dropped until a byte with end_of_buffer set, which
// returns the parser to its start and resets the buffer position.
// max_length may only be written while no beat is in flight.
module octal_netstring_parser
  import onp_pkg::*;
#(
  parameter int POS_BITS = ONP_POS_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input byte channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  // length limit register
  input  logic                 cfg_wr_en,
  input  logic [ONP_LEN_W-1:0] cfg_wr_data
);

  // frame state
  frame_st_t            st_r;
  frame_st_t            st_nxt;
  logic [POS_BITS-1:0]  pos_r;
  logic [POS_BITS-1:0]  pos_nxt;
  logic [POS_BITS-1:0]  start_r;
  logic [POS_BITS-1:0]  start_nxt;
  logic [ONP_LEN_W-1:0] max_length_r;

  // result register
  out_beat_t            res_nxt;
  out_beat_t            out_data_r;
  logic                 out_valid_r;

  logic                 in_accept;

  // stall only while a finished result is held and the sink is stalling
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  onp_step #(
    .POS_BITS(POS_BITS)
  ) u_step (
    .beat_i       (in_data),
    .max_length_i (max_length_r),
    .st_i         (st_r),
    .pos_i        (pos_r),
    .start_i      (start_r),
    .st_o         (st_nxt),
    .pos_o        (pos_nxt),
    .start_o      (start_nxt),
    .res_o        (res_nxt)
  );

  // limit register, reset to the largest length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= '1;
    end else if (cfg_wr_en) begin
      max_length_r <= cfg_wr_data;
    end
  end

  // frame state advances on every accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '{phase: PH_WS, length_acc: '0, remaining: '0, digit_seen: 1'b0};
      pos_r   <= '0;
      start_r <= '0;
    end else if (in_accept) begin
      st_r    <= st_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/onp_step.sv =====
// ----------------------------------------------------------------------------
// onp_step: per-byte parse step
// next frame state, next position and the result beat for one input byte
// ----------------------------------------------------------------------------
module onp_step
  import onp_pkg::*;
#(
  parameter int POS_BITS = ONP_POS_BITS
) (
  input  in_beat_t             beat_i,
  input  logic [ONP_LEN_W-1:0] max_length_i,
  input  frame_st_t            st_i,
  input  logic [POS_BITS-1:0]  pos_i,
  input  logic [POS_BITS-1:0]  start_i,
  output frame_st_t            st_o,
  output logic [POS_BITS-1:0]  pos_o,
  output logic [POS_BITS-1:0]  start_o,
  output out_beat_t            res_o
);

  logic [7:0]             c;
  logic                   is_digit;
  logic                   is_ws;
  logic                   do_len;
  logic                   frame_open;
  logic [ONP_LEN_W+2:0]   acc_v;
  logic [ONP_LEN_W-1:0]   rem_dec;
  logic [POS_BITS-1:0]    next_pos;
  logic [POS_BITS+ONP_OFF_W-1:0] start_ext;
  logic [POS_BITS+ONP_OFF_W-1:0] next_ext;

  assign c         = beat_i.in_byte;
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_SEVEN);
  assign is_ws     = (c == CH_CR) || (c == CH_LF) || (c == CH_TAB) || (c == CH_SPACE);
  // times eight plus the digit value is a plain concatenation
  assign acc_v     = {st_i.length_acc, c[2:0]};
  assign rem_dec   = st_i.remaining - 1'b1;
  assign next_pos  = pos_i + 1'b1;
  assign start_ext = {{ONP_OFF_W{1'b0}}, start_i};
  assign next_ext  = {{ONP_OFF_W{1'b0}}, next_pos};

  always_comb begin
    st_o    = st_i;
    start_o = start_i;
    res_o   = '0;
    do_len  = 1'b0;

    unique case (st_i.phase)
      PH_LEN: begin
        do_len = 1'b1;
      end
      PH_DATA: begin
        res_o.kind         = KIND_BYTE;
        res_o.payload_byte = c;
        st_o.remaining     = rem_dec;
        if (rem_dec == '0) begin
          st_o.phase = PH_COMMA;
        end
      end
      PH_COMMA: begin
        if (c == CH_COMMA) begin
          res_o.kind         = KIND_DONE;
          res_o.frame_offset = start_ext[ONP_OFF_W-1:0];
          res_o.frame_length = st_i.length_acc;
          res_o.next_offset  = next_ext[ONP_OFF_W-1:0];
          st_o    = '{phase: PH_WS, length_acc: '0, remaining: '0, digit_seen: 1'b0};
          start_o = '0;
        end else begin
          res_o.kind   = KIND_ERR;
          res_o.status = ST_FMT;
          st_o.phase   = PH_DROP;
        end
      end
      PH_DROP: begin
      end
      default: begin
        // whitespace skip; first other byte falls into length parsing
        do_len = !is_ws;
      end
    endcase

    if (do_len) begin
      if (is_digit) begin
        if (acc_v > {3'b000, max_length_i}) begin
          res_o.kind   = KIND_ERR;
          res_o.status = ST_BIG;
          st_o.phase   = PH_DROP;
        end else begin
          st_o.length_acc = acc_v[ONP_LEN_W-1:0];
          st_o.digit_seen = 1'b1;
          st_o.phase      = PH_LEN;
        end
      end else if ((c == CH_COLON) && st_i.digit_seen) begin
        start_o        = next_pos;
        st_o.remaining = st_i.length_acc;
        st_o.phase     = (st_i.length_acc == '0) ? PH_COMMA : PH_DATA;
      end else begin
        res_o.kind   = KIND_ERR;
        res_o.status = ST_FMT;
        st_o.phase   = PH_DROP;
      end
    end

    frame_open = (st_o.phase == PH_LEN) || (st_o.phase == PH_DATA) ||
                 (st_o.phase == PH_COMMA);

    if (beat_i.end_of_buffer) begin
      if ((res_o.kind != KIND_ERR) && frame_open) begin
        res_o        = '0;
        res_o.kind   = KIND_ERR;
        res_o.status = ST_INC;
      end
      st_o    = '{phase: PH_WS, length_acc: '0, remaining: '0, digit_seen: 1'b0};
      start_o = '0;
      pos_o   = '0;
    end else begin
      pos_o = next_pos;
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the octal netstring parser
// ----------------------------------------------------------------------------
// Sends byte beats into the parser and checks every result beat against a
// predictor of the deframing rules. The bench covers whitespace skipping,
// octal length prefixes, payload passing, the comma check, the length limit,
// and the error and incomplete reports. Directed buffers come first, then
// random buffers that are mostly well-formed frames with some broken ones
// and noise. Random sender gaps and receiver stalls are applied, with one
// long hold-off on the receiver so that the parser back-pressures.
// ----------------------------------------------------------------------------
module tb_top;
  import onp_pkg::*;

  localparam int HOLD_CYCLES  = 60;
  localparam int PRINT_CAP    = 100;
  localparam int WATCHDOG_NS  = 1_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data     = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_wr_en   = 1'b0;
  logic [ONP_LEN_W-1:0] cfg_wr_data = '0;

  // parser state as the predictor sees it
  phase_t                  parse_phase;
  logic [ONP_LEN_W-1:0]    prefix_len;
  logic [ONP_LEN_W-1:0]    bytes_left;
  logic                    have_digit;
  logic [ONP_POS_BITS-1:0] buf_pos;
  logic [ONP_POS_BITS-1:0] payload_pos;
  logic [ONP_LEN_W-1:0]    length_limit;

  out_beat_t  parse_results_due[$];
  logic [7:0] stream_bytes[$];

  int mismatches   = 0;
  int results_seen = 0;

  // idling knobs; the percentages and hold requests change only at a rising edge
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_acks = 0;
  int hold_left = 0;

  octal_netstring_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("FAIL");
    $finish;
  end

  // works out the result beat of one byte and advances the predicted state
  function automatic out_beat_t parse_byte(input in_beat_t beat);
    out_beat_t               r;
    logic [7:0]              c;
    logic [ONP_POS_BITS-1:0] nxt;
    logic                    is_digit;
    logic                    is_space;
    int unsigned             grown;
    phase_t                  eff;
    r        = '0;
    c        = beat.in_byte;
    nxt      = buf_pos + 1'b1;
    is_digit = (c >= CH_ZERO) && (c <= CH_SEVEN);
    is_space = (c == CH_CR) || (c == CH_LF) || (c == CH_TAB) || (c == CH_SPACE);
    eff      = parse_phase;
    // first non-blank byte is taken as part of the length prefix
    if (parse_phase == PH_WS && !is_space) eff = PH_LEN;
    case (eff)
      PH_LEN: begin
        if (is_digit) begin
          grown = 32'(prefix_len) * 8 + 32'(c - CH_ZERO);
          if (grown > 32'(length_limit)) begin
            r.kind      = KIND_ERR;
            r.status    = ST_BIG;
            parse_phase = PH_DROP;
          end else begin
            prefix_len  = grown[ONP_LEN_W-1:0];
            have_digit  = 1'b1;
            parse_phase = PH_LEN;
          end
        end else if (c == CH_COLON && have_digit) begin
          payload_pos = nxt;
          bytes_left  = prefix_len;
          parse_phase = (prefix_len == 0) ? PH_COMMA : PH_DATA;
        end else begin
          r.kind      = KIND_ERR;
          r.status    = ST_FMT;
          parse_phase = PH_DROP;
        end
      end
      PH_DATA: begin
        r.kind         = KIND_BYTE;
        r.payload_byte = c;
        bytes_left     = bytes_left - 1'b1;
        if (bytes_left == 0) parse_phase = PH_COMMA;
      end
      PH_COMMA: begin
        if (c == CH_COMMA) begin
          r.kind         = KIND_DONE;
          r.frame_offset = ONP_OFF_W'(payload_pos);
          r.frame_length = prefix_len;
          r.next_offset  = ONP_OFF_W'(nxt);
          parse_phase    = PH_WS;
          prefix_len     = '0;
          bytes_left     = '0;
          have_digit     = 1'b0;
          payload_pos    = '0;
        end else begin
          r.kind      = KIND_ERR;
          r.status    = ST_FMT;
          parse_phase = PH_DROP;
        end
      end
      default: begin
      end
    endcase
    if (beat.end_of_buffer) begin
      // an open frame at the end mark overrides whatever the byte gave
      if (r.kind != KIND_ERR &&
          (parse_phase == PH_LEN || parse_phase == PH_DATA || parse_phase == PH_COMMA)) begin
        r        = '0;
        r.kind   = KIND_ERR;
        r.status = ST_INC;
      end
      parse_phase = PH_WS;
      prefix_len  = '0;
      bytes_left  = '0;
      have_digit  = 1'b0;
      payload_pos = '0;
      buf_pos     = '0;
    end else begin
      buf_pos = nxt;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got,
               want);
  endtask

  // checks each result beat, then records the prediction for a byte taken
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (parse_results_due.size() == 0) begin
          report_mismatch("result with nothing expected, kind", out_data.kind, '0);
        end else begin
          want = parse_results_due.pop_front();
          if (out_data.kind !== want.kind)
            report_mismatch("kind", out_data.kind, want.kind);
          if (out_data.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", out_data.payload_byte, want.payload_byte);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.frame_offset !== want.frame_offset)
            report_mismatch("frame_offset", out_data.frame_offset, want.frame_offset);
          if (out_data.frame_length !== want.frame_length)
            report_mismatch("frame_length", out_data.frame_length, want.frame_length);
          if (out_data.next_offset !== want.next_offset)
            report_mismatch("next_offset", out_data.next_offset, want.next_offset);
        end
        results_seen++;
      end
      if (in_valid && !in_stall) parse_results_due.push_back(parse_byte(in_data));
    end
  end

  // receiver side: random stalls, plus a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_acks) begin
      hold_acks <= hold_reqs;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // offers one byte beat and holds it until taken; called at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, end_of_buffer: eob};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // sends the staged buffer with the end mark on its last byte
  task automatic send_stream();
    for (int i = 0; i < stream_bytes.size(); i++)
      send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    stream_bytes.delete();
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) stream_bytes.push_back(s[i]);
  endtask

  // stops offering so the last beat is not taken twice, then changes the mix
  task automatic set_idling(input int send_gap_pct, input int recv_stall_pct);
    in_valid <= 1'b0;
    @(posedge clk);
    idle_pct  = send_gap_pct;
    stall_pct = recv_stall_pct;
    @(negedge clk);
  endtask

  // stops offering and waits until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (parse_results_due.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_max_length(input logic [ONP_LEN_W-1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    length_limit  = v;
  endtask

  // blanks, a two-byte frame with extreme payload values, a zero-length frame
  task automatic test_basic_frames();
    stream_bytes.push_back(CH_CR);
    stream_bytes.push_back(CH_LF);
    stream_bytes.push_back(CH_TAB);
    stream_bytes.push_back(CH_SPACE);
    queue_text("2:");
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hFF);
    queue_text(",0:, ");
    send_stream();
  endtask

  // format errors, incomplete frames and the drop phase
  task automatic test_error_cases();
    queue_text(":q");   // colon without digits
    send_stream();
    queue_text("1xy");  // bad byte in the prefix, then dropped
    send_stream();
    queue_text("8");    // non-octal digit
    send_stream();
    queue_text("12");   // end mark inside the prefix
    send_stream();
    queue_text("1:a");  // end mark on a payload byte
    send_stream();
    queue_text("0:");   // end mark while the comma is due
    send_stream();
    queue_text("1:ab"); // comma missing
    send_stream();
  endtask

  // limit at both extremes
  task automatic test_length_limit();
    write_max_length('0);
    queue_text("0:,");
    send_stream();
    queue_text("1");
    send_stream();
    write_max_length('1);
    queue_text("177777:");
    send_stream();
    queue_text("200000");
    send_stream();
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    set_idling(0, 0);
    @(posedge clk);
    hold_reqs = hold_reqs + 1;
    @(negedge clk);
    repeat (2) begin
      queue_text("12:");
      repeat (10) stream_bytes.push_back(8'($urandom_range(255)));
      queue_text(",");
      send_stream();
    end
  endtask

  // stages one random buffer: mostly frames, some broken, some noise
  task automatic make_random_buffer();
    int         nframes;
    int         roll;
    int         len;
    int         v;
    int         cut;
    logic [7:0] digs[$];
    nframes = $urandom_range(1, 3);
    repeat (nframes) begin
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(3))
          0: stream_bytes.push_back(CH_CR);
          1: stream_bytes.push_back(CH_LF);
          2: stream_bytes.push_back(CH_TAB);
          default: stream_bytes.push_back(CH_SPACE);
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 80) len = $urandom_range(0, 6);
      else if (roll < 92) len = $urandom_range(7, 40);
      else len = $urandom_range(41, 65535);
      digs.delete();
      v = len;
      do begin
        digs.push_front(8'(CH_ZERO + v % 8));
        v = v / 8;
      end while (v != 0);
      if ($urandom_range(4) == 0) digs.push_front(CH_ZERO);
      foreach (digs[i]) stream_bytes.push_back(digs[i]);
      stream_bytes.push_back(CH_COLON);
      // long prefixes get only three payload bytes, so their frames run short
      repeat ((len > 40) ? 3 : len) stream_bytes.push_back(8'($urandom_range(255)));
      stream_bytes.push_back(CH_COMMA);
    end
    roll = $urandom_range(99);
    if (roll < 15) begin
      stream_bytes[$urandom_range(stream_bytes.size() - 1)] = 8'($urandom_range(255));
    end else if (roll < 25) begin
      cut = $urandom_range(1, stream_bytes.size());
      while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
    end else if (roll < 32) begin
      stream_bytes.delete();
      repeat ($urandom_range(1, 8)) stream_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_traffic(input int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      make_random_buffer();
      sent += stream_bytes.size();
      send_stream();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    parse_phase  = PH_WS;
    prefix_len   = '0;
    bytes_left   = '0;
    have_digit   = 1'b0;
    buf_pos      = '0;
    payload_pos  = '0;
    length_limit = '1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_basic_frames();
    test_error_cases();
    test_length_limit();
    test_backpressure();

    // random phases, each with its own idling mix and length limit
    write_max_length('1);
    set_idling(0, 0);
    test_random_traffic(70);
    write_max_length(16'd20);
    set_idling(54, 0);
    test_random_traffic(70);
    write_max_length(16'd5);
    set_idling(0, 54);
    test_random_traffic(70);
    write_max_length(ONP_LEN_W'($urandom_range(1, 40)));
    set_idling(31, 31);
    test_random_traffic(70);
    write_max_length('1);
    set_idling(0, 0);
    test_random_traffic(15);

    wait_idle();
    repeat (4) @(negedge clk);
    if (parse_results_due.size() != 0)
      report_mismatch("results still expected", parse_results_due.size(), 0);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
